[hw/rtl/poisson_stencil_residual_unit_assert.svh]
// Assertion macros of the residual unit RTL.
`ifndef POISSON_STENCIL_RESIDUAL_UNIT_ASSERT_SVH
`define POISSON_STENCIL_RESIDUAL_UNIT_ASSERT_SVH

// Property checked on every rising clk_i edge outside reset.
`define PSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication from an antecedent to a consequent in the same cycle.
`define PSR_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hw/rtl/psr_pkg.sv]
// Types and constants of the Poisson stencil residual unit.
package psr_pkg;

  localparam int unsigned SolW      = 24;
  localparam int unsigned ResW      = 32;
  localparam int unsigned DimW      = 11;
  localparam int unsigned RatioW    = 16;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CoefW     = 19;
  localparam int unsigned LrSumW    = 25;
  localparam int unsigned LrProdW   = 42;
  localparam int unsigned CProdW    = 43;
  localparam int unsigned LinW      = 26;
  localparam int unsigned SumW      = 46;
  localparam int unsigned FracShift = 12;
  localparam int unsigned MinDim    = 2;
  localparam int unsigned DimReset  = 1024;
  localparam int unsigned RatioReset = 4096;
  // The constant two in Q4.12 and one half of the Q.28 to Q.16 step.
  localparam int unsigned TwoQ12    = 8192;
  localparam int unsigned RoundHalf = 2048;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_COLS     = 2'd0,
    CFG_GRID_ROWS     = 2'd1,
    CFG_SPACING_RATIO = 2'd2
  } cfg_index_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_FLUSH  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic signed [SolW-1:0] sol_value;
    logic signed [SolW-1:0] rhs_value;
  } in_item_t;

  typedef struct packed {
    logic signed [ResW-1:0] residual;
    logic                   last_point;
    logic                   saturated;
  } out_item_t;

  // One column of the line store: middle row, row above and middle-row rhs.
  typedef struct packed {
    logic signed [SolW-1:0] mid;
    logic signed [SolW-1:0] above;
    logic signed [SolW-1:0] rhs;
  } line_word_t;

  typedef struct packed {
    logic emit;
    logic wr;
    logic has_up;
    logic has_left;
    logic has_right;
    logic last;
  } point_ctl_t;

endpackage

[hw/rtl/psr_ram.sv]
// Generic RAM: one write port, two read ports, registered read data.
module psr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_a_q;
  logic [Width-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_a_q <= mem_q[raddr_a_i];
    rd_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

[hw/rtl/psr_stencil_dp.sv]
// Stencil arithmetic: products, rounding to Q16.16 and saturation.
module psr_stencil_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  psr_pkg::point_ctl_t                    ctl_i,
  input  logic signed [psr_pkg::SolW-1:0]        center_i,
  input  logic signed [psr_pkg::SolW-1:0]        above_i,
  input  logic signed [psr_pkg::SolW-1:0]        right_i,
  input  logic signed [psr_pkg::SolW-1:0]        left_i,
  input  logic signed [psr_pkg::SolW-1:0]        down_i,
  input  logic signed [psr_pkg::SolW-1:0]        rhs_i,
  input  logic [psr_pkg::RatioW-1:0]             ratio_i,
  input  logic signed [psr_pkg::CoefW-1:0]       coef_i,
  output logic                                   valid_o,
  output psr_pkg::out_item_t                     item_o
);

  localparam int unsigned QW = psr_pkg::SumW - psr_pkg::FracShift;

  logic signed [psr_pkg::SolW-1:0]    l_val, r_val, u_val, d_val;
  logic signed [psr_pkg::LrSumW-1:0]  lr_sum;
  logic signed [psr_pkg::RatioW:0]    ratio_s;
  logic signed [psr_pkg::LrProdW-1:0] p_lr_d, p_lr_q;
  logic signed [psr_pkg::CProdW-1:0]  p_c_d, p_c_q;
  logic signed [psr_pkg::LinW-1:0]    lin_d, lin_q;
  logic                               last_q;
  logic                               v_q;
  logic signed [psr_pkg::SumW-1:0]    sum;
  logic signed [QW-1:0]               q_full;
  logic                               sat;

  // Neighbors outside the grid count as zero.
  assign l_val   = ctl_i.has_left  ? left_i  : '0;
  assign r_val   = ctl_i.has_right ? right_i : '0;
  assign u_val   = ctl_i.has_up    ? above_i : '0;
  assign d_val   = ctl_i.wr        ? down_i  : '0;
  assign lr_sum  = l_val + r_val;
  assign ratio_s = {1'b0, ratio_i};
  assign p_lr_d  = lr_sum * ratio_s;
  assign p_c_d   = coef_i * center_i;
  assign lin_d   = u_val + d_val - rhs_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    p_lr_q <= p_lr_d;
    p_c_q  <= p_c_d;
    lin_q  <= lin_d;
    last_q <= ctl_i.last;
  end

  assign sum = psr_pkg::SumW'(p_lr_q) + psr_pkg::SumW'(p_c_q)
             + (psr_pkg::SumW'(lin_q) <<< psr_pkg::FracShift)
             + psr_pkg::SumW'(psr_pkg::RoundHalf);

  // Arithmetic shift floors toward minus infinity.
  assign q_full = sum[psr_pkg::SumW-1:psr_pkg::FracShift];
  assign sat    = (q_full[QW-1:psr_pkg::ResW-1] != '0)
               && (q_full[QW-1:psr_pkg::ResW-1] != '1);

  always_comb begin
    item_o.last_point = last_q;
    item_o.saturated  = sat;
    if (!sat) begin
      item_o.residual = q_full[psr_pkg::ResW-1:0];
    end else if (q_full[QW-1]) begin
      item_o.residual = {1'b1, {(psr_pkg::ResW-1){1'b0}}};
    end else begin
      item_o.residual = {1'b0, {(psr_pkg::ResW-1){1'b1}}};
    end
  end

  assign valid_o = v_q;

endmodule

[hw/rtl/psr_out_fifo.sv]
// Small output queue that holds finished results until they are taken.
module psr_out_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  psr_pkg::out_item_t         item_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output psr_pkg::out_item_t         item_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  psr_pkg::out_item_t slot_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign item_o  = slot_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[hw/rtl/poisson_stencil_residual_unit.sv]
// Top level of the streaming five-point Laplacian residual unit.
// The unit takes one grid sample or flush transfer per clock while input
// ready is high. It gives the residual of each point one row after the point
// itself, when the sample just below it is taken. The last row is drained by
// one flush transfer per column. A result passes the read-modify-write stage
// register, the datapath register and the output queue on its way out.
// The line store is one RAM of MAX_COLS words with one write and two read
// ports; each transfer reads its column and the next in the cycle it is
// taken; a sample writes its column back in the next cycle, with forwarding
// when the two touch the same word. Input ready drops only when four items
// are in flight or queued, so a stalled output holds back at most that many.
// The store needs no clearing pass after reset. A write to any of the three
// configuration registers restarts the grid at its first point.
`include "poisson_stencil_residual_unit_assert.svh"

module poisson_stencil_residual_unit #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  psr_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output psr_pkg::out_item_t              out_item_o,
  input  logic                            cfg_we_i,
  input  logic [psr_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [psr_pkg::CfgW-1:0]        cfg_wdata_i
);

  localparam int unsigned AddrW     = $clog2(MAX_COLS);
  localparam int unsigned ColW      = $clog2(MAX_COLS + 1);
  localparam int unsigned RowW      = $clog2(MAX_ROWS + 1);
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);
  localparam int unsigned OccW      = CntW + 1;
  localparam int unsigned ColsReset =
    (MAX_COLS < psr_pkg::DimReset) ? MAX_COLS : psr_pkg::DimReset;
  localparam int unsigned RowsReset =
    (MAX_ROWS < psr_pkg::DimReset) ? MAX_ROWS : psr_pkg::DimReset;
  localparam int unsigned WordW     = $bits(psr_pkg::line_word_t);
  localparam logic signed [psr_pkg::CoefW-1:0] CoefReset =
    -(psr_pkg::CoefW'(psr_pkg::TwoQ12 + 2 * psr_pkg::RatioReset));

  // Configuration.
  logic [ColW-1:0]                   cols_q, cols_d;
  logic [RowW-1:0]                   rows_q, rows_d;
  logic [psr_pkg::RatioW-1:0]        ratio_q, ratio_d;
  logic signed [psr_pkg::CoefW-1:0]  coef_q, coef_d;
  logic [psr_pkg::DimW-1:0]          dim_val;
  logic [psr_pkg::CoefW-1:0]         coef_mag;
  logic                              cfg_restart;

  // Grid position.
  logic [AddrW-1:0] col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;

  // Input stage.
  logic             in_fire;
  logic [AddrW-1:0] x;
  logic [ColW-1:0]  x_inc;
  logic             at_row_end;
  logic             draining;
  logic             take_sample, take_flush, take;
  logic [AddrW-1:0] rd_a_addr, rd_b_addr;
  psr_pkg::point_ctl_t ctl_d;

  // Read-modify-write stage.
  logic                          s1_v_q;
  psr_pkg::point_ctl_t           s1_ctl_q;
  logic [AddrW-1:0]              s1_addr_q;
  logic signed [psr_pkg::SolW-1:0] s1_sol_q, s1_rhs_q;
  logic                          fwd_a_q, fwd_b_q;
  psr_pkg::line_word_t           fwd_word_q;
  psr_pkg::line_word_t           rd_a_word, rd_b_word, word_a, wr_word;
  logic signed [psr_pkg::SolW-1:0] right_val, left_q;
  logic [WordW-1:0]              rd_a_raw, rd_b_raw;
  logic                          ram_we;

  // Results.
  logic               dp_valid;
  psr_pkg::out_item_t dp_item;
  logic [CntW-1:0]    fifo_cnt;
  logic [OccW-1:0]    occupancy;

  // ---------------------------------------------------------------- config
  assign dim_val  = cfg_wdata_i[psr_pkg::DimW-1:0];
  assign coef_mag = psr_pkg::CoefW'(psr_pkg::TwoQ12)
                  + psr_pkg::CoefW'({cfg_wdata_i[psr_pkg::RatioW-1:0], 1'b0});

  always_comb begin
    cols_d      = cols_q;
    rows_d      = rows_q;
    ratio_d     = ratio_q;
    coef_d      = coef_q;
    cfg_restart = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        psr_pkg::CFG_GRID_COLS: begin
          cfg_restart = 1'b1;
          if (32'(dim_val) < psr_pkg::MinDim) begin
            cols_d = ColW'(psr_pkg::MinDim);
          end else if (32'(dim_val) > MAX_COLS) begin
            cols_d = ColW'(MAX_COLS);
          end else begin
            cols_d = ColW'(dim_val);
          end
        end
        psr_pkg::CFG_GRID_ROWS: begin
          cfg_restart = 1'b1;
          if (32'(dim_val) < psr_pkg::MinDim) begin
            rows_d = RowW'(psr_pkg::MinDim);
          end else if (32'(dim_val) > MAX_ROWS) begin
            rows_d = RowW'(MAX_ROWS);
          end else begin
            rows_d = RowW'(dim_val);
          end
        end
        psr_pkg::CFG_SPACING_RATIO: begin
          cfg_restart = 1'b1;
          ratio_d     = cfg_wdata_i[psr_pkg::RatioW-1:0];
          coef_d      = -coef_mag;
        end
        default: begin
          cfg_restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= ColW'(ColsReset);
      rows_q  <= RowW'(RowsReset);
      ratio_q <= psr_pkg::RatioW'(psr_pkg::RatioReset);
      coef_q  <= CoefReset;
    end else begin
      cols_q  <= cols_d;
      rows_q  <= rows_d;
      ratio_q <= ratio_d;
      coef_q  <= coef_d;
    end
  end

  // ----------------------------------------------------------- input stage
  assign x           = (ColW'(col_q) >= cols_q) ? '0 : col_q;
  assign x_inc       = ColW'(x) + ColW'(1);
  assign at_row_end  = (x_inc >= cols_q);
  assign draining    = (row_q >= rows_q);
  assign take_sample = (in_item_i.op == psr_pkg::OP_SAMPLE) && !draining;
  assign take_flush  = (in_item_i.op == psr_pkg::OP_FLUSH) && draining;
  assign take        = take_sample || take_flush;

  assign occupancy  = OccW'(fifo_cnt) + OccW'(s1_v_q) + OccW'(dp_valid);
  assign in_ready_o = (occupancy < OccW'(FifoDepth));
  assign in_fire    = in_valid_i && in_ready_o;

  assign rd_a_addr = x;
  assign rd_b_addr = x_inc[AddrW-1:0];

  always_comb begin
    ctl_d.emit      = take_flush || (row_q != '0);
    ctl_d.wr        = take_sample;
    ctl_d.has_up    = take_flush || (row_q >= RowW'(2));
    ctl_d.has_left  = (x != '0);
    ctl_d.has_right = !at_row_end;
    ctl_d.last      = take_flush && at_row_end;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_restart) begin
      col_d = '0;
      row_d = '0;
    end else if (in_fire && take) begin
      if (!at_row_end) begin
        col_d = x_inc[AddrW-1:0];
      end else if (take_sample) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        // The flush of the last column ends the grid.
        col_d = '0;
        row_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      s1_v_q  <= 1'b0;
      fwd_a_q <= 1'b0;
      fwd_b_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      s1_v_q  <= in_fire && take;
      // A write in flight to a word being read now is passed on directly.
      fwd_a_q <= ram_we && (s1_addr_q == rd_a_addr);
      fwd_b_q <= ram_we && (s1_addr_q == rd_b_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ctl_q   <= ctl_d;
    s1_addr_q  <= x;
    s1_sol_q   <= in_item_i.sol_value;
    s1_rhs_q   <= in_item_i.rhs_value;
    fwd_word_q <= wr_word;
  end

  // ------------------------------------------------------ line store (RMW)
  psr_ram #(
    .Width (WordW),
    .Depth (MAX_COLS)
  ) u_line_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (s1_addr_q),
    .wdata_i   (wr_word),
    .raddr_a_i (rd_a_addr),
    .rdata_a_o (rd_a_raw),
    .raddr_b_i (rd_b_addr),
    .rdata_b_o (rd_b_raw)
  );

  assign rd_a_word = psr_pkg::line_word_t'(rd_a_raw);
  assign rd_b_word = psr_pkg::line_word_t'(rd_b_raw);
  assign word_a    = fwd_a_q ? fwd_word_q : rd_a_word;
  assign right_val = fwd_b_q ? fwd_word_q.mid : rd_b_word.mid;

  // The middle row moves up and the new sample takes its place.
  assign ram_we        = s1_v_q && s1_ctl_q.wr;
  assign wr_word.mid   = s1_sol_q;
  assign wr_word.above = word_a.mid;
  assign wr_word.rhs   = s1_rhs_q;

  // The left neighbor is the center of the previous point.
  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      left_q <= word_a.mid;
    end
  end

  // ------------------------------------------------------------ arithmetic
  psr_stencil_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_v_q && s1_ctl_q.emit),
    .ctl_i    (s1_ctl_q),
    .center_i (word_a.mid),
    .above_i  (word_a.above),
    .right_i  (right_val),
    .left_i   (left_q),
    .down_i   (s1_sol_q),
    .rhs_i    (word_a.rhs),
    .ratio_i  (ratio_q),
    .coef_i   (coef_q),
    .valid_o  (dp_valid),
    .item_o   (dp_item)
  );

  psr_out_fifo #(
    .Depth (FifoDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (dp_valid),
    .item_i  (dp_item),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .item_o  (out_item_o),
    .count_o (fifo_cnt)
  );

  // ------------------------------------------------------------ assertions
  `PSR_ASSERT_IMPLIES(psr_fifo_no_overflow, dp_valid, fifo_cnt < CntW'(FifoDepth), "queue overflow")
  `PSR_ASSERT(psr_col_in_range, ColW'(col_q) < cols_q, "column counter beyond grid width")
  `PSR_ASSERT(psr_end_of_grid, (in_fire && ctl_d.last) |=> ({row_q, col_q} == '0), "grid not reset")
  `PSR_ASSERT_IMPLIES(psr_dp_from_stage, dp_valid, $past(s1_v_q && s1_ctl_q.emit), "stray result")

endmodule
